@@ rtl/core/fatcw_pkg.sv @@
// Shared definitions for the FAT chain walker and allocator.
// Holds table sizes, link codes, operation and status codes and the sequencer states.
// No dependencies.
package fatcw_pkg;

  localparam int MAX_BLOCKS = 8192;
  localparam int ADDR_W     = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = 14;
  localparam int LINK_W     = 16;

  localparam logic [LINK_W-1:0] END_OF_CHAIN = 16'hFFFF;
  localparam logic [LINK_W-1:0] FREE_LINK    = 16'h0000;
  localparam logic [CNT_W-1:0]  COUNT_RESET  = CNT_W'(MAX_BLOCKS);

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_DUMP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_ENDED = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDENT,
    ST_WCHK,
    ST_WWAIT,
    ST_SCAN,
    ST_LINK,
    ST_DONE
  } state_t;

endpackage

@@ rtl/core/fat_chain_walk_allocator.sv @@
// Top level of the FAT chain walker and allocator: table memory and its sequencer.
// Depends on fatcw_pkg.
//
// Usage: one request enters on the in_ stream and one result leaves on the out_ stream.
// in_tuser carries the operation; load and dump address single table entries, read
// follows a chain to the requested logical block and write does the same while giving
// an empty chain a first block and extending a short chain with the lowest free blocks.
// The cfg_ channel sets the number of entries in use; the user must write it only while
// idle, and the block itself does not enforce this. After reset the table is cleared one
// entry per cycle, and no request is taken until that pass is over.
// Load writes its entry on transfer; dump reads it and captures the value in ST_RDENT.
// Each link followed is a read on the single table read port, issued in ST_WCHK and
// taken in ST_WWAIT. A free search reads entries from the lowest upward in ST_SCAN;
// ST_LINK marks a block added at the chain end, and a write adds its searches to a read's walk.
// One request is in work at a time; a new one is taken as soon as the previous result
// sits in the output register, even while the receiver stalls it. A finished result
// waits in the sequencer until the output register is free.
module fat_chain_walk_allocator
  import fatcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] cfg_data,     // data_block_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,     // start_block, block_number, entry_index, entry_value
  input  logic [1:0]  in_tuser,     // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,    // physical_block, chain_start, entry_data
  output logic [1:0]  out_tuser     // status
);

  logic [LINK_W-1:0] mem [MAX_BLOCKS];
  logic [LINK_W-1:0] mem_q_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [LINK_W-1:0] mem_wdata;

  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  status_t           status_r, status_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  eff_count;
  logic [LINK_W-1:0] blk_r, blk_nxt;
  logic [LINK_W-1:0] chain_r, chain_nxt;
  logic [LINK_W-1:0] phys_r, phys_nxt;
  logic [LINK_W-1:0] data_r, data_nxt;
  logic [ADDR_W-1:0] nblk_r, nblk_nxt;
  logic [ADDR_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [ADDR_W-1:0] prev_idx_r, prev_idx_nxt;
  logic              prev_valid_r, prev_valid_nxt;
  logic              ext_r, ext_nxt;
  logic [ADDR_W-1:0] nb_r, nb_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [47:0]       out_data_r, out_data_nxt;
  logic [1:0]        out_user_r, out_user_nxt;

  logic              in_xfer;
  logic              blk_in_range;
  logic              scan_hit;
  logic [LINK_W-1:0] in_start;
  logic [ADDR_W-1:0] in_nblk, in_eidx;
  logic [LINK_W-1:0] in_eval;

  assign in_start = in_tdata[15:0];
  assign in_nblk  = in_tdata[28:16];
  assign in_eidx  = in_tdata[41:29];
  assign in_eval  = in_tdata[57:42];

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign eff_count    = (count_r > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : count_r;
  assign blk_in_range = (blk_r < {2'b00, eff_count});
  assign scan_hit     = prev_valid_r && (mem_q_r == FREE_LINK);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      count_r      <= COUNT_RESET;
      scan_idx_r   <= '0;
      prev_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_idx_r   <= scan_idx_nxt;
      prev_valid_r <= prev_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    status_r   <= status_nxt;
    blk_r      <= blk_nxt;
    chain_r    <= chain_nxt;
    phys_r     <= phys_nxt;
    data_r     <= data_nxt;
    nblk_r     <= nblk_nxt;
    step_r     <= step_nxt;
    prev_idx_r <= prev_idx_nxt;
    ext_r      <= ext_nxt;
    nb_r       <= nb_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    status_nxt     = status_r;
    blk_nxt        = blk_r;
    chain_nxt      = chain_r;
    phys_nxt       = phys_r;
    data_nxt       = data_r;
    nblk_nxt       = nblk_r;
    step_nxt       = step_r;
    scan_idx_nxt   = scan_idx_r;
    prev_idx_nxt   = prev_idx_r;
    prev_valid_nxt = prev_valid_r;
    ext_nxt        = ext_r;
    nb_nxt         = nb_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = scan_idx_r[ADDR_W-1:0];
        mem_wdata    = FREE_LINK;
        scan_idx_nxt = scan_idx_r + 1'b1;
        if (scan_idx_r == CNT_W'(MAX_BLOCKS - 1)) begin
          scan_idx_nxt = '0;
          state_nxt    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          mode_nxt   = mode_t'(in_tuser);
          status_nxt = STAT_OK;
          blk_nxt    = in_start;
          chain_nxt  = in_start;
          phys_nxt   = '0;
          data_nxt   = '0;
          nblk_nxt   = in_nblk;
          step_nxt   = '0;
          case (mode_t'(in_tuser))
            MODE_LOAD: begin
              mem_we    = 1'b1;
              mem_waddr = in_eidx;
              mem_wdata = in_eval;
              state_nxt = ST_DONE;
            end
            MODE_DUMP: begin
              mem_re    = 1'b1;
              mem_raddr = in_eidx;
              state_nxt = ST_RDENT;
            end
            MODE_WRITE: begin
              if (in_start == END_OF_CHAIN) begin
                ext_nxt        = 1'b0;
                scan_idx_nxt   = '0;
                prev_valid_nxt = 1'b0;
                state_nxt      = ST_SCAN;
              end else begin
                state_nxt = ST_WCHK;
              end
            end
            default: begin
              state_nxt = ST_WCHK;
            end
          endcase
        end
      end
      ST_RDENT: begin
        data_nxt  = mem_q_r;
        state_nxt = ST_DONE;
      end
      ST_WCHK: begin
        if ((mode_r == MODE_READ) && (blk_r == END_OF_CHAIN)) begin
          status_nxt = STAT_ENDED;
          state_nxt  = ST_DONE;
        end else if (!blk_in_range) begin
          status_nxt = STAT_RANGE;
          state_nxt  = ST_DONE;
        end else if (step_r == nblk_r) begin
          phys_nxt  = blk_r;
          state_nxt = ST_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = blk_r[ADDR_W-1:0];
          state_nxt = ST_WWAIT;
        end
      end
      ST_WWAIT: begin
        if ((mode_r == MODE_WRITE) && (mem_q_r == END_OF_CHAIN)) begin
          ext_nxt        = 1'b1;
          scan_idx_nxt   = '0;
          prev_valid_nxt = 1'b0;
          state_nxt      = ST_SCAN;
        end else begin
          blk_nxt   = mem_q_r;
          step_nxt  = step_r + 1'b1;
          state_nxt = ST_WCHK;
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          prev_valid_nxt = 1'b0;
          if (!ext_r) begin
            mem_we    = 1'b1;
            mem_waddr = prev_idx_r;
            mem_wdata = END_OF_CHAIN;
            blk_nxt   = LINK_W'(prev_idx_r);
            chain_nxt = LINK_W'(prev_idx_r);
            state_nxt = ST_WCHK;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = blk_r[ADDR_W-1:0];
            mem_wdata = LINK_W'(prev_idx_r);
            nb_nxt    = prev_idx_r;
            state_nxt = ST_LINK;
          end
        end else if (scan_idx_r < eff_count) begin
          mem_re         = 1'b1;
          mem_raddr      = scan_idx_r[ADDR_W-1:0];
          prev_valid_nxt = 1'b1;
          prev_idx_nxt   = scan_idx_r[ADDR_W-1:0];
          scan_idx_nxt   = scan_idx_r + 1'b1;
        end else begin
          prev_valid_nxt = 1'b0;
          status_nxt     = STAT_FULL;
          state_nxt      = ST_DONE;
        end
      end
      ST_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = nb_r;
        mem_wdata = END_OF_CHAIN;
        blk_nxt   = LINK_W'(nb_r);
        step_nxt  = step_r + 1'b1;
        state_nxt = ST_WCHK;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {data_r, chain_r, (status_r == STAT_OK) ? phys_r : FREE_LINK};
          out_user_nxt  = status_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
